FILE: hw/rtl/rcl_pkg.sv
// ============================================================================
// rcl_pkg
// Shared types and constants for the robust control law pipeline.
// ============================================================================
`default_nettype none

package rcl_pkg;

    // Control law select codes.
    localparam logic [1:0] MODE_SLIDING   = 2'd0;
    localparam logic [1:0] MODE_HIGH_GAIN = 2'd1;
    localparam logic [1:0] MODE_HIGH_FREQ = 2'd2;

    // Register word indexes on the APB port.
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_TARGET  = 2'd1;
    localparam logic [1:0] REG_RATE    = 2'd2;
    localparam logic [1:0] REG_EPSILON = 2'd3;

    // Divider geometry: |b2*err| over a 31-bit positive denominator,
    // 32 quotient bits plus an overflow flag.
    localparam int unsigned NUM_W = 63;
    localparam int unsigned DEN_W = 31;
    localparam int unsigned QUO_W = 32;

    // Values riding alongside the divider.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] base;
        logic [30:0]        b;
        logic               err_neg;
        logic               err_zero;
        logic               clip;
    } t_side;

endpackage

`default_nettype wire

FILE: hw/rtl/rcl_div.sv
// ============================================================================
// rcl_div
// Pipelined restoring divider, one quotient bit per stage, with overflow.
// ============================================================================
`default_nettype none

module rcl_div
    import rcl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire t_side             i_side,
    output logic                   o_vld,
    output logic [QUO_W-1:0]       o_quo,
    output logic                   o_ovf,
    output t_side                  o_side
);

    logic             r_vld  [0:QUO_W];
    logic [DEN_W-1:0] r_rem  [0:QUO_W];
    logic [QUO_W-1:0] r_sh   [0:QUO_W];   // dividend bits out the top, quotient in
    logic [DEN_W-1:0] r_den  [0:QUO_W];
    logic             r_ovf  [0:QUO_W];
    t_side            r_side [0:QUO_W];

    // Load stage: quotient would need more than QUO_W bits if the upper
    // dividend part already reaches the denominator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num[NUM_W-1 -: DEN_W];
            r_sh[0]   <= i_num[QUO_W-1:0];
            r_den[0]  <= i_den;
            r_ovf[0]  <= (i_num[NUM_W-1 -: DEN_W] >= i_den);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0] n_part;
        logic [DEN_W:0] n_dext;
        logic [DEN_W:0] n_diff;
        logic           n_ge;
        logic [DEN_W-1:0] n_rem;

        always_comb begin
            n_part = {r_rem[k-1], r_sh[k-1][QUO_W-1]};
            n_dext = {1'b0, r_den[k-1]};
            n_ge   = (n_part >= n_dext);
            n_diff = n_part - n_dext;
            n_rem  = n_ge ? n_diff[DEN_W-1:0] : n_part[DEN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_sh[k]   <= {r_sh[k-1][QUO_W-2:0], n_ge};
                r_den[k]  <= r_den[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[QUO_W];
    assign o_quo  = r_sh[QUO_W];
    assign o_ovf  = r_ovf[QUO_W];
    assign o_side = r_side[QUO_W];

endmodule

`default_nettype wire

FILE: hw/rtl/robust_control_law_top.sv
// ============================================================================
// robust_control_law_top
// Robust control law: one saturated drive value per plant state sample.
// ============================================================================
//
//  Channel  | Direction | Signals                          | Contents
//  ---------+-----------+----------------------------------+---------------------------
//  state in | sink      | s_tvalid s_tready s_tdata[31:0]  | measured_state (Q16.16)
//  drive out| source    | m_tvalid m_tready m_tdata[31:0]  | drive (Q16.16)
//           |           | m_tuser[0]                       | saturated flag
//  config   | APB slave | psel penable pwrite paddr[3:0]   | control_mode, target,
//           |           | pwdata prdata pready             | target_rate, epsilon
//
//  One sample enters per clock while s_tready is high. There are 41 register
//  stages (6 arithmetic stages, 33 divider stages, a term stage and the
//  output register). The divider resolves one quotient bit per stage, which
//  sets the depth. Stalls freeze the whole pipeline only when the output
//  register is full and the stage ahead of it holds a result; bubbles in
//  that stage are filled while the output waits. Reset is synchronous and
//  clears the valid bits and the configuration registers.
//
`default_nettype none

module robust_control_law_top
    import rcl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // sample in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] measured_state
    // drive out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [31:0] drive
    output logic [0:0]       m_tuser,    // [0] saturated
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // 0.1 and 2.0 in the chosen fixed-point format
    localparam logic [63:0] ONE_TENTH  = 64'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [31:0] TARGET_RST = 32'(64'd2 << FRAC_BITS);
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]         r_mode;
    logic signed [31:0] r_target;
    logic signed [31:0] r_rate;
    logic [30:0]        r_eps;
    logic [30:0]        eps_eff;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    // zero epsilon acts as one LSB so the divider never sees zero
    assign eps_eff = (r_eps == '0) ? 31'd1 : r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SLIDING;
            r_target <= TARGET_RST;
            r_rate   <= '0;
            r_eps    <= ONE_TENTH[30:0];
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:    r_mode   <= pwdata[1:0];
                REG_TARGET:  r_target <= pwdata;
                REG_RATE:    r_rate   <= pwdata;
                REG_EPSILON: r_eps    <= pwdata[30:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:    prdata = {30'd0, r_mode};
            REG_TARGET:  prdata = r_target;
            REG_RATE:    prdata = r_rate;
            REG_EPSILON: prdata = {1'b0, r_eps};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. The output register loads when empty or drained; the
    // rest of the pipe also moves while its last stage is empty.
    // ------------------------------------------------------------------
    logic r_st_vld;
    logic r_out_vld;
    logic out_en;
    logic pipe_en;

    assign out_en   = !r_out_vld || m_tready;
    assign pipe_en  = out_en || !r_st_vld;
    assign s_tready = pipe_en;

    // ------------------------------------------------------------------
    // S1: error against target, |x|
    // ------------------------------------------------------------------
    logic               r_s1_vld;
    logic signed [31:0] r_s1_err;
    logic               r_s1_clip;
    logic [31:0]        r_s1_ax;
    logic [1:0]         r_s1_mode;
    logic signed [32:0] n_s1_diff;
    logic signed [31:0] n_s1_err;
    logic               n_s1_clip;

    always_comb begin
        n_s1_diff = {r_target[31], r_target} - {s_tdata[31], s_tdata};
        n_s1_clip = (n_s1_diff[32] != n_s1_diff[31]);
        if (n_s1_clip) begin
            n_s1_err = n_s1_diff[32] ? MIN32 : MAX32;
        end else begin
            n_s1_err = n_s1_diff[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_err  <= n_s1_err;
            r_s1_clip <= n_s1_clip;
            r_s1_ax   <= s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
            r_s1_mode <= r_mode;
        end
    end

    // ------------------------------------------------------------------
    // S2: x*x, base = err + target_rate, |err|
    // ------------------------------------------------------------------
    logic               r_s2_vld;
    logic [63:0]        r_s2_pxx;
    logic signed [31:0] r_s2_base;
    logic [31:0]        r_s2_aerr;
    logic               r_s2_neg;
    logic               r_s2_zero;
    logic               r_s2_clip;
    logic [1:0]         r_s2_mode;
    logic signed [32:0] n_s2_sum;
    logic signed [31:0] n_s2_base;
    logic               n_s2_clip;

    always_comb begin
        n_s2_sum  = {r_s1_err[31], r_s1_err} + {r_rate[31], r_rate};
        n_s2_clip = (n_s2_sum[32] != n_s2_sum[31]);
        if (n_s2_clip) begin
            n_s2_base = n_s2_sum[32] ? MIN32 : MAX32;
        end else begin
            n_s2_base = n_s2_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s2_pxx  <= 64'(r_s1_ax) * 64'(r_s1_ax);
            r_s2_base <= n_s2_base;
            r_s2_aerr <= r_s1_err[31] ? (~r_s1_err + 32'd1) : r_s1_err;
            r_s2_neg  <= r_s1_err[31];
            r_s2_zero <= (r_s1_err == '0);
            r_s2_clip <= r_s1_clip || n_s2_clip;
            r_s2_mode <= r_s1_mode;
        end
    end

    // ------------------------------------------------------------------
    // S3: b = x*x + 0.1, saturated (never negative)
    // ------------------------------------------------------------------
    logic               r_s3_vld;
    logic [30:0]        r_s3_b;
    logic [31:0]        r_s3_aerr;
    logic signed [31:0] r_s3_base;
    logic               r_s3_neg;
    logic               r_s3_zero;
    logic               r_s3_clip;
    logic [1:0]         r_s3_mode;
    logic [63:0]        n_s3_sum;
    logic               n_s3_clip;

    always_comb begin
        n_s3_sum  = (r_s2_pxx >> FRAC_BITS) + ONE_TENTH;
        n_s3_clip = |n_s3_sum[63:31];
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s3_b    <= n_s3_clip ? '1 : n_s3_sum[30:0];
            r_s3_aerr <= r_s2_aerr;
            r_s3_base <= r_s2_base;
            r_s3_neg  <= r_s2_neg;
            r_s3_zero <= r_s2_zero;
            r_s3_clip <= r_s2_clip || n_s3_clip;
            r_s3_mode <= r_s2_mode;
        end
    end

    // ------------------------------------------------------------------
    // S4: b*b and b*|err|
    // ------------------------------------------------------------------
    logic               r_s4_vld;
    logic [61:0]        r_s4_pbb;
    logic [62:0]        r_s4_pbe;
    logic [30:0]        r_s4_b;
    logic [31:0]        r_s4_aerr;
    logic signed [31:0] r_s4_base;
    logic               r_s4_neg;
    logic               r_s4_zero;
    logic               r_s4_clip;
    logic [1:0]         r_s4_mode;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s4_pbb  <= 62'(r_s3_b) * 62'(r_s3_b);
            r_s4_pbe  <= 63'(r_s3_b) * 63'(r_s3_aerr);
            r_s4_b    <= r_s3_b;
            r_s4_aerr <= r_s3_aerr;
            r_s4_base <= r_s3_base;
            r_s4_neg  <= r_s3_neg;
            r_s4_zero <= r_s3_zero;
            r_s4_clip <= r_s3_clip;
            r_s4_mode <= r_s3_mode;
        end
    end

    // ------------------------------------------------------------------
    // S5: b2 = b*b scaled, denominator for the chosen law
    // ------------------------------------------------------------------
    logic               r_s5_vld;
    logic [30:0]        r_s5_b2;
    logic [30:0]        r_s5_den;
    logic [30:0]        r_s5_b;
    logic [31:0]        r_s5_aerr;
    logic signed [31:0] r_s5_base;
    logic               r_s5_neg;
    logic               r_s5_zero;
    logic               r_s5_clip;
    logic [1:0]         r_s5_mode;
    logic [61:0]        n_s5_bb;
    logic               n_s5_bclip;
    logic [63:0]        n_s5_hf;
    logic               n_s5_dclip;
    logic               n_s5_is_hg;
    logic               n_s5_is_hf;

    always_comb begin
        n_s5_bb    = r_s4_pbb >> FRAC_BITS;
        n_s5_bclip = |n_s5_bb[61:31];
        n_s5_hf    = 64'(r_s4_pbe >> FRAC_BITS) + 64'(eps_eff);
        n_s5_dclip = |n_s5_hf[63:31];
        n_s5_is_hg = (r_s4_mode == MODE_HIGH_GAIN);
        // mode 3 falls in with the high frequency law
        n_s5_is_hf = (r_s4_mode != MODE_SLIDING) && !n_s5_is_hg;
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s5_b2   <= n_s5_bclip ? '1 : n_s5_bb[30:0];
            r_s5_den  <= n_s5_is_hg ? eps_eff : (n_s5_dclip ? '1 : n_s5_hf[30:0]);
            r_s5_b    <= r_s4_b;
            r_s5_aerr <= r_s4_aerr;
            r_s5_base <= r_s4_base;
            r_s5_neg  <= r_s4_neg;
            r_s5_zero <= r_s4_zero;
            r_s5_clip <= r_s4_clip
                         || ((r_s4_mode != MODE_SLIDING) && n_s5_bclip)
                         || (n_s5_is_hf && n_s5_dclip);
            r_s5_mode <= r_s4_mode;
        end
    end

    // ------------------------------------------------------------------
    // S6: |numerator| = b2 * |err|
    // ------------------------------------------------------------------
    logic               r_s6_vld;
    logic [NUM_W-1:0]   r_s6_num;
    logic [DEN_W-1:0]   r_s6_den;
    t_side              r_s6_side;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s6_num           <= NUM_W'(r_s5_b2) * NUM_W'(r_s5_aerr);
            r_s6_den           <= r_s5_den;
            r_s6_side.mode     <= r_s5_mode;
            r_s6_side.base     <= r_s5_base;
            r_s6_side.b        <= r_s5_b;
            r_s6_side.err_neg  <= r_s5_neg;
            r_s6_side.err_zero <= r_s5_zero;
            r_s6_side.clip     <= r_s5_clip;
        end
    end

    // valid bits of S1..S6
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s1_vld <= s_tvalid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    // ------------------------------------------------------------------
    // Divider: |num| / den, 33 stages
    // ------------------------------------------------------------------
    logic             dv_vld;
    logic [QUO_W-1:0] dv_quo;
    logic             dv_ovf;
    t_side            dv_side;

    rcl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_s6_vld),
        .i_num   (r_s6_num),
        .i_den   (r_s6_den),
        .i_side  (r_s6_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_ovf   (dv_ovf),
        .o_side  (dv_side)
    );

    // ------------------------------------------------------------------
    // ST: robust term with sign and saturation
    // ------------------------------------------------------------------
    logic signed [31:0] r_st_term;
    logic signed [31:0] r_st_base;
    logic               r_st_clip;
    logic signed [31:0] n_st_term;
    logic               n_st_clip;

    always_comb begin
        n_st_clip = 1'b0;
        if (dv_side.mode == MODE_SLIDING) begin
            // sign(0) is 0
            if (dv_side.err_zero) begin
                n_st_term = '0;
            end else if (dv_side.err_neg) begin
                n_st_term = -$signed({1'b0, dv_side.b});
            end else begin
                n_st_term = $signed({1'b0, dv_side.b});
            end
        end else if (!dv_side.err_neg) begin
            if (dv_ovf || dv_quo[QUO_W-1]) begin
                n_st_term = MAX32;
                n_st_clip = 1'b1;
            end else begin
                n_st_term = $signed(dv_quo);
            end
        end else begin
            // negative side reaches one step further
            if (dv_ovf || (dv_quo[QUO_W-1] && (|dv_quo[QUO_W-2:0]))) begin
                n_st_term = MIN32;
                n_st_clip = 1'b1;
            end else begin
                n_st_term = $signed(~dv_quo + 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= 1'b0;
        end else if (pipe_en) begin
            r_st_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_st_term <= n_st_term;
            r_st_base <= dv_side.base;
            r_st_clip <= dv_side.clip || n_st_clip;
        end
    end

    // ------------------------------------------------------------------
    // Output register: drive = base + term, saturated
    // ------------------------------------------------------------------
    logic signed [31:0] r_out_drive;
    logic               r_out_sat;
    logic signed [32:0] n_out_sum;
    logic signed [31:0] n_out_drive;
    logic               n_out_clip;

    always_comb begin
        n_out_sum  = {r_st_base[31], r_st_base} + {r_st_term[31], r_st_term};
        n_out_clip = (n_out_sum[32] != n_out_sum[31]);
        if (n_out_clip) begin
            n_out_drive = n_out_sum[32] ? MIN32 : MAX32;
        end else begin
            n_out_drive = n_out_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= r_st_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_drive <= n_out_drive;
            r_out_sat   <= r_st_clip || n_out_clip;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_drive;
    assign m_tuser  = r_out_sat;

endmodule

`default_nettype wire

FILE: hw/rtl/rcl_chk.sv
// ============================================================================
// rcl_chk
// Port-level checks for the robust control law block, bound to the top.
// ============================================================================
`default_nettype none

module rcl_chk
    import rcl_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an empty output register never blocks the sample side
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("sample side blocked with empty output");

    // nothing comes out right after reset
    a_rst_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    // target register reads back what was just written
    a_target_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n && psel && penable && pwrite && paddr[3:2] == REG_TARGET)
        && psel && !pwrite && paddr[3:2] == REG_TARGET |-> prdata == $past(pwdata))
        else $error("target readback mismatch");

endmodule

bind robust_control_law_top rcl_chk u_rcl_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

`default_nettype wire
